// File: hdl/pswc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pswc_pkg
// Types and sizing for the per-source sliding window counter: word formats,
// register indexes and the widths that follow from the source count and the
// depth of the arrival queue.
// ----------------------------------------------------------------------------
package pswc_pkg;

	localparam int NUM_SOURCES = 10;
	localparam int FIFO_DEPTH  = 1024;

	localparam int SRC_W   = 4;
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 8;
	localparam int COUNT_W = 11;

	localparam int SIDX_W = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int PTR_W  = $clog2(FIFO_DEPTH);
	localparam int OCC_W  = $clog2(FIFO_DEPTH + 1);

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam int CFG_IDX_W = 1;
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW_SECONDS  = 1'b0,
		REG_REPORT_INTERVAL = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SRC_W-1:0]  source_number;
		logic [TIME_W-1:0] now_seconds;
	} in_word_t;

	typedef struct packed {
		logic [SRC_W-1:0]   report_source;
		logic [COUNT_W-1:0] window_count;
		logic               overflowed;
		logic               last_line;
	} out_word_t;

endpackage
`default_nettype wire

// File: hdl/per_source_window_counter_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// per_source_window_counter_unit
// Counts arrivals per source over a sliding time window and emits a report
// of all source counts when an arrival finds that the report interval has passed.
// ----------------------------------------------------------------------------
// One arrival word is taken at a time. Each word first has the report
// interval checked; when a report is due, NUM_SOURCES report lines follow,
// one per cycle unless the output side stalls. The word is then appended,
// and the oldest queue entries are aged out one by one (a read of the queue
// memory, then the age compare on the shared 32-bit subtract-compare unit)
// until one is still in the window or the queue is empty. in_ready is high
// only between arrivals. The arrival queue is a single-port memory with a
// registered read; it needs no clearing after reset.
// ----------------------------------------------------------------------------
module per_source_window_counter_unit
	import pswc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire in_word_t             in_data,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      out_word_t            out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_REPORT,
		ST_APPEND,
		ST_EVICT_RD,
		ST_EVICT_CMP
	} state_t;

	typedef struct packed {
		logic [SIDX_W-1:0] src;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	state_t                state_q;
	logic [SRC_W-1:0]      src_q;
	logic [TIME_W-1:0]     now_q;
	logic [TIME_W-1:0]     last_report_q;
	logic [CFG_W-1:0]      window_q;
	logic [CFG_W-1:0]      interval_q;
	logic [PTR_W-1:0]      oldest_q;
	logic [PTR_W-1:0]      newest_q;
	logic [OCC_W-1:0]      occ_q;
	logic                  overflow_q;
	logic [SIDX_W-1:0]     rpt_idx_q;
	logic [OCC_W-1:0]      count_q [NUM_SOURCES];
	logic                  out_valid_q;
	out_word_t             out_q;

	entry_t                mem [FIFO_DEPTH];
	entry_t                rd_q;

	// shared age unit
	logic [TIME_W-1:0]     age_base;
	logic [CFG_W-1:0]      age_limit;
	logic [TIME_W-1:0]     age_diff;
	logic                  age_over;

	logic [SIDX_W-1:0]     cnt_sel;
	logic [OCC_W-1:0]      cnt_rd;
	logic                  src_ok;
	logic                  fifo_full;
	logic                  out_load;
	logic                  rpt_last;
	logic [PTR_W-1:0]      oldest_nxt;
	logic [PTR_W-1:0]      newest_nxt;
	logic [COUNT_W-1:0]    cnt_sat;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		if (state_q == ST_CHECK) begin
			age_base  = last_report_q;
			age_limit = interval_q;
		end else begin
			age_base  = rd_q.stamp;
			age_limit = window_q;
		end
		age_diff = now_q - age_base;
		age_over = age_diff > TIME_W'(age_limit);
	end

	// one counter read port, address picked by the sequencer
	always_comb begin
		unique case (state_q)
			ST_REPORT:    cnt_sel = rpt_idx_q;
			ST_EVICT_CMP: cnt_sel = rd_q.src;
			default:      cnt_sel = src_q[SIDX_W-1:0];
		endcase
	end
	assign cnt_rd = count_q[cnt_sel];

	assign src_ok     = (32'(src_q) < NUM_SOURCES);
	assign fifo_full  = (occ_q == OCC_W'(FIFO_DEPTH));
	assign out_load   = (state_q == ST_REPORT) && (!out_valid_q || out_ready);
	assign rpt_last   = (32'(rpt_idx_q) == NUM_SOURCES - 1);
	assign oldest_nxt = (32'(oldest_q) == FIFO_DEPTH - 1) ? '0 : oldest_q + 1'b1;
	assign newest_nxt = (32'(newest_q) == FIFO_DEPTH - 1) ? '0 : newest_q + 1'b1;
	assign cnt_sat    = (32'(cnt_rd) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(cnt_rd);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			src_q         <= '0;
			now_q         <= '0;
			last_report_q <= '0;
			window_q      <= CFG_W'(2);
			interval_q    <= CFG_W'(1);
			oldest_q      <= '0;
			newest_q      <= '0;
			occ_q         <= '0;
			overflow_q    <= 1'b0;
			rpt_idx_q     <= '0;
			out_valid_q   <= 1'b0;
			for (int i = 0; i < NUM_SOURCES; i++) begin
				count_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_WINDOW_SECONDS:  window_q   <= cfg_wdata;
					REG_REPORT_INTERVAL: interval_q <= cfg_wdata;
					default:             ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						src_q   <= in_data.source_number;
						now_q   <= in_data.now_seconds;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					rpt_idx_q <= '0;
					if (age_over) begin
						last_report_q <= now_q;
						state_q       <= ST_REPORT;
					end else begin
						state_q <= ST_APPEND;
					end
				end
				ST_REPORT: begin
					if (out_load) begin
						rpt_idx_q <= rpt_idx_q + 1'b1;
						if (rpt_last) begin
							state_q <= ST_APPEND;
						end
					end
				end
				ST_APPEND: begin
					if (src_ok) begin
						if (fifo_full) begin
							overflow_q <= 1'b1;
						end else begin
							newest_q         <= newest_nxt;
							occ_q            <= occ_q + 1'b1;
							count_q[cnt_sel] <= cnt_rd + 1'b1;
						end
					end
					state_q <= ST_EVICT_RD;
				end
				ST_EVICT_RD: begin
					if (occ_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_EVICT_CMP;
					end
				end
				ST_EVICT_CMP: begin
					if (age_over) begin
						if (cnt_rd != '0) begin
							count_q[cnt_sel] <= cnt_rd - 1'b1;
						end
						oldest_q <= oldest_nxt;
						occ_q    <= occ_q - 1'b1;
						state_q  <= ST_EVICT_RD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// report word, captured before this arrival is counted
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.report_source <= SRC_W'(rpt_idx_q);
			out_q.window_count  <= cnt_sat;
			out_q.overflowed    <= overflow_q;
			out_q.last_line     <= rpt_last;
		end
	end

	// arrival queue
	always_ff @(posedge clk) begin
		if (state_q == ST_APPEND && src_ok && !fifo_full) begin
			mem[newest_q] <= '{src: src_q[SIDX_W-1:0], stamp: now_q};
		end
		if (state_q == ST_EVICT_RD) begin
			rd_q <= mem[oldest_q];
		end
	end

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(occ_q) <= FIFO_DEPTH)
		else $error("queue occupancy above depth");

	a_empty_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (oldest_q == newest_q))
		else $error("empty queue with pointers apart");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflow_q) |-> (32'($past(occ_q)) == FIFO_DEPTH))
		else $error("overflow flagged while queue not full");

	a_last_src: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.last_line) |-> (32'(out_q.report_source) == NUM_SOURCES - 1))
		else $error("last report line on wrong source");

	a_ready_no_report: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPORT && out_load && rpt_last) |=> !in_ready)
		else $error("arrival taken before append and evict");

endmodule
`default_nettype wire
